### hdl/rect_overlap_merge_split_unit_assert.svh
// ----------------------------------------------------------------------------
// rect_overlap_merge_split_unit_assert
// assertion helpers for the rectangle merge / split unit
// ----------------------------------------------------------------------------
`ifndef RECT_OVERLAP_MERGE_SPLIT_UNIT_ASSERT_SVH
`define RECT_OVERLAP_MERGE_SPLIT_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define ROMSU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define ROMSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/romsu_pkg.sv
// ----------------------------------------------------------------------------
// romsu_pkg
// types, codes and edge helpers shared by the rectangle merge / split unit
// ----------------------------------------------------------------------------
package romsu_pkg;

    localparam int C_COORD_W = 16;

    localparam logic signed [C_COORD_W-1:0] C_COORD_MAX = {1'b0, {(C_COORD_W-1){1'b1}}};
    localparam logic signed [C_COORD_W-1:0] C_COORD_MIN = {1'b1, {(C_COORD_W-1){1'b0}}};

    // action codes
    localparam logic C_ACT_MERGE = 1'b0;
    localparam logic C_ACT_SPLIT = 1'b1;

    // overlap case bits
    localparam logic [3:0] C_CASE_LEFT   = 4'h8;
    localparam logic [3:0] C_CASE_TOP    = 4'h4;
    localparam logic [3:0] C_CASE_RIGHT  = 4'h2;
    localparam logic [3:0] C_CASE_BOTTOM = 4'h1;
    localparam logic [3:0] C_CASE_MASK   = 4'hf;

    // overlap cases, named by which edges of A lie past the same edge of B
    // (left, top, right, bottom)
    localparam logic [3:0] C_OV_NONE = 4'h0;
    localparam logic [3:0] C_OV_B    = 4'h1;
    localparam logic [3:0] C_OV_R    = 4'h2;
    localparam logic [3:0] C_OV_RB   = 4'h3;
    localparam logic [3:0] C_OV_T    = 4'h4;
    localparam logic [3:0] C_OV_TB   = 4'h5;
    localparam logic [3:0] C_OV_TR   = 4'h6;
    localparam logic [3:0] C_OV_TRB  = 4'h7;
    localparam logic [3:0] C_OV_L    = 4'h8;
    localparam logic [3:0] C_OV_LB   = 4'h9;
    localparam logic [3:0] C_OV_LR   = 4'ha;
    localparam logic [3:0] C_OV_LRB  = 4'hb;
    localparam logic [3:0] C_OV_LT   = 4'hc;
    localparam logic [3:0] C_OV_LTB  = 4'hd;
    localparam logic [3:0] C_OV_LTR  = 4'he;
    localparam logic [3:0] C_OV_LTRB = 4'hf;

    typedef logic signed [C_COORD_W-1:0] t_coord;

    typedef struct packed {
        t_coord left;
        t_coord top;
        t_coord right;
        t_coord bottom;
    } t_rect;

    typedef struct packed {
        logic   action;
        t_coord a_left;
        t_coord a_top;
        t_coord a_right;
        t_coord a_bottom;
        t_coord b_left;
        t_coord b_top;
        t_coord b_right;
        t_coord b_bottom;
    } t_item;

    typedef struct packed {
        t_coord     rect_left;
        t_coord     rect_top;
        t_coord     rect_right;
        t_coord     rect_bottom;
        logic [1:0] slot;
        logic [1:0] rect_count;
        logic       empty_res;
        logic       last;
    } t_result;

    // classified item handed from front to back
    typedef struct packed {
        logic       action;
        logic [3:0] code;
        t_rect      a;
        t_rect      b;
    } t_job;

    // saturating edge step
    function automatic t_coord f_inc(t_coord v);
        return (v == C_COORD_MAX) ? v : t_coord'(v + t_coord'(1));
    endfunction

    function automatic t_coord f_dec(t_coord v);
        return (v == C_COORD_MIN) ? v : t_coord'(v - t_coord'(1));
    endfunction

    function automatic t_rect f_mk(t_coord l, t_coord t, t_coord r, t_coord b);
        t_rect x;
        x.left   = l;
        x.top    = t;
        x.right  = r;
        x.bottom = b;
        return x;
    endfunction

endpackage

### hdl/rect_overlap_merge_split_unit.sv
// ----------------------------------------------------------------------------
// rect_overlap_merge_split_unit
// disjoint union (merge) or difference (split) of two inclusive rectangles
// ----------------------------------------------------------------------------
// usage
//   input: drive i_item and raise start; the item is taken at a rising edge
//   where start is high and busy is low. busy rises only when the job queue
//   is full, so several items may be in flight at once
//   output: each result rectangle sits on o_result for one cycle with
//   o_strobe high; the receiver cannot stall, results never wait
//   an item gives rect_count results in slots 0..rect_count-1, last on the
//   final one; when split leaves nothing, one result with empty_res set
// path: an accepted item goes through the job queue, the back end's
//   rectangle registers and the registered result port
// sending: one rectangle per cycle from the back end to the single result
//   port; the next queued job is taken as a job's last result is registered
// reset: synchronous, active low; empties the queue and drops any results
//   still to be sent. o_strobe is low after reset
// ----------------------------------------------------------------------------
module rect_overlap_merge_split_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  romsu_pkg::t_item   i_item,
    output logic               o_strobe,
    output romsu_pkg::t_result o_result
);

    localparam int JOB_W = $bits(romsu_pkg::t_job);

    // front to queue
    logic            push;
    romsu_pkg::t_job front_job;

    // queue to back
    logic            q_valid, q_full, pop;
    logic [JOB_W-1:0] q_data;
    romsu_pkg::t_job head_job;

    assign busy     = q_full;
    assign head_job = romsu_pkg::t_job'(q_data);

    // classify the overlap case as the item comes in
    romsu_front u_front (
        .i_start (start),
        .i_full  (q_full),
        .i_item  (i_item),
        .o_push  (push),
        .o_job   (front_job)
    );

    // decouples intake from result sending
    romsu_queue #(
        .P_WIDTH (JOB_W),
        .P_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (JOB_W'(front_job)),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_data  (q_data)
    );

    // edge arithmetic and one result per cycle
    romsu_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_job    (head_job),
        .o_pop    (pop),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

`include "rect_overlap_merge_split_unit_assert.svh"

    // the closing result of an item sits in its highest slot
    `ROMSU_ASSERT_NOW(a_last_slot, i_clk, i_rst_n, o_strobe && o_result.last && !o_result.empty_res, o_result.slot == 2'(o_result.rect_count - 2'd1), "last result not in top slot")

    // an empty result stands alone
    `ROMSU_ASSERT_NOW(a_empty_alone, i_clk, i_rst_n, o_strobe && o_result.empty_res, o_result.last && (o_result.rect_count == 2'd0) && (o_result.slot == 2'd0), "empty result malformed")

    // results of one item follow back to back in rising slots
    `ROMSU_ASSERT_NEXT(a_slot_run, i_clk, i_rst_n, o_strobe && !o_result.last, o_strobe && (o_result.slot == 2'($past(o_result.slot) + 2'd1)), "gap or slot skip within an item")

endmodule

### hdl/romsu_front.sv
// ----------------------------------------------------------------------------
// romsu_front
// takes an item, forms the 4-bit overlap case and pushes the job to the queue
// ----------------------------------------------------------------------------
module romsu_front (
    input  logic            i_start,
    input  logic            i_full,
    input  romsu_pkg::t_item i_item,
    output logic            o_push,
    output romsu_pkg::t_job  o_job
);

    logic [3:0] code;

    always_comb begin
        code = 4'h0;
        if (i_item.a_left > i_item.b_left) begin
            code = code | romsu_pkg::C_CASE_LEFT;
        end
        if (i_item.a_top > i_item.b_top) begin
            code = code | romsu_pkg::C_CASE_TOP;
        end
        if (i_item.a_right > i_item.b_right) begin
            code = code | romsu_pkg::C_CASE_RIGHT;
        end
        if (i_item.a_bottom > i_item.b_bottom) begin
            code = code | romsu_pkg::C_CASE_BOTTOM;
        end
        code = code & romsu_pkg::C_CASE_MASK;
    end

    assign o_push       = i_start && !i_full;
    assign o_job.action = i_item.action;
    assign o_job.code   = code;
    assign o_job.a      = romsu_pkg::f_mk(i_item.a_left, i_item.a_top,
                                          i_item.a_right, i_item.a_bottom);
    assign o_job.b      = romsu_pkg::f_mk(i_item.b_left, i_item.b_top,
                                          i_item.b_right, i_item.b_bottom);

endmodule

### hdl/romsu_queue.sv
// ----------------------------------------------------------------------------
// romsu_queue
// short first-in first-out queue of jobs between front and back
// ----------------------------------------------------------------------------
module romsu_queue #(
    parameter int P_WIDTH = 8,
    parameter int P_DEPTH = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [P_WIDTH-1:0] i_data,
    input  logic               i_pop,
    output logic               o_valid,
    output logic               o_full,
    output logic [P_WIDTH-1:0] o_data
);

    localparam int PTR_W = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CNT_W = $clog2(P_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(P_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(P_DEPTH);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               do_push, do_pop;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == CNT_FULL);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : PTR_W'(r_wr_ptr + 1'b1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : PTR_W'(r_rd_ptr + 1'b1);
        end
        if (do_push && !do_pop) begin
            n_cnt = CNT_W'(r_cnt + 1'b1);
        end else if (do_pop && !do_push) begin
            n_cnt = CNT_W'(r_cnt - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### hdl/romsu_back.sv
// ----------------------------------------------------------------------------
// romsu_back
// works out the result rectangles of a job and sends them one per cycle
// ----------------------------------------------------------------------------
module romsu_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  romsu_pkg::t_job    i_job,
    output logic               o_pop,
    output logic               o_strobe,
    output romsu_pkg::t_result o_result
);

    romsu_pkg::t_rect  ra, rb, rx, ea;
    romsu_pkg::t_coord al, at, ar, ab, bl, bt, br, bb;
    logic [1:0]        n;

    romsu_pkg::t_rect  r_rect [3];
    logic [1:0]        r_idx, r_count, r_last;
    logic              r_active, r_strobe;
    romsu_pkg::t_result r_out, n_out;
    romsu_pkg::t_rect  sel;
    logic              done, take;

    assign al = i_job.a.left;
    assign at = i_job.a.top;
    assign ar = i_job.a.right;
    assign ab = i_job.a.bottom;
    assign bl = i_job.b.left;
    assign bt = i_job.b.top;
    assign br = i_job.b.right;
    assign bb = i_job.b.bottom;

    // per-case edge arithmetic
    always_comb begin
        ra = i_job.a;
        rb = i_job.b;
        rx = '0;
        n  = 2'd1;
        if (i_job.action == romsu_pkg::C_ACT_MERGE) begin
            case (i_job.code)
                romsu_pkg::C_OV_NONE: begin
                    rx = romsu_pkg::f_mk(romsu_pkg::f_inc(ar), bt, br, bb);
                    rb.right = ar;
                    rb.top = romsu_pkg::f_inc(ab);
                    n = 2'd3;
                end
                romsu_pkg::C_OV_B: begin rb.left = romsu_pkg::f_inc(ar); n = 2'd2; end
                romsu_pkg::C_OV_R: begin rb.top = romsu_pkg::f_inc(ab); n = 2'd2; end
                romsu_pkg::C_OV_RB: begin n = 2'd1; end
                romsu_pkg::C_OV_T: begin ra.right = romsu_pkg::f_dec(bl); n = 2'd2; end
                romsu_pkg::C_OV_TB: begin
                    rx = romsu_pkg::f_mk(romsu_pkg::f_inc(ar), bt, br, bb);
                    rb.right = ar;
                    rb.bottom = romsu_pkg::f_dec(at);
                    n = 2'd3;
                end
                romsu_pkg::C_OV_TR: begin
                    rx = romsu_pkg::f_mk(bl, bt, br, romsu_pkg::f_dec(at));
                    rb.top = romsu_pkg::f_inc(ab);
                    n = 2'd3;
                end
                romsu_pkg::C_OV_TRB: begin rb.bottom = romsu_pkg::f_dec(at); n = 2'd2; end
                romsu_pkg::C_OV_L: begin ra.bottom = romsu_pkg::f_dec(bt); n = 2'd2; end
                romsu_pkg::C_OV_LB: begin
                    rx = romsu_pkg::f_mk(bl, bt, romsu_pkg::f_dec(al), bb);
                    rb.left = romsu_pkg::f_inc(ar);
                    n = 2'd3;
                end
                romsu_pkg::C_OV_LR: begin
                    rx = romsu_pkg::f_mk(bl, bt, romsu_pkg::f_dec(al), bb);
                    rb.left = al;
                    rb.top = romsu_pkg::f_inc(ab);
                    n = 2'd3;
                end
                romsu_pkg::C_OV_LRB: begin rb.right = romsu_pkg::f_dec(al); n = 2'd2; end
                romsu_pkg::C_OV_LT: begin ra = i_job.b; n = 2'd1; end
                romsu_pkg::C_OV_LTB: begin ra.top = romsu_pkg::f_inc(bb); n = 2'd2; end
                romsu_pkg::C_OV_LTR: begin ra.left = romsu_pkg::f_inc(br); n = 2'd2; end
                default: begin
                    rx = romsu_pkg::f_mk(bl, bt, romsu_pkg::f_dec(al), bb);
                    rb.left = al;
                    rb.bottom = romsu_pkg::f_dec(at);
                    n = 2'd3;
                end
            endcase
        end else begin
            case (i_job.code)
                romsu_pkg::C_OV_NONE: begin
                    rb = romsu_pkg::f_mk(al, bt, romsu_pkg::f_dec(bl), ab);
                    ra.bottom = romsu_pkg::f_dec(bt);
                    n = 2'd2;
                end
                romsu_pkg::C_OV_B: begin
                    rx = romsu_pkg::f_mk(al, romsu_pkg::f_inc(bb), ar, ab);
                    rb = romsu_pkg::f_mk(al, bt, romsu_pkg::f_dec(bl), bb);
                    ra.bottom = romsu_pkg::f_dec(bt);
                    n = 2'd3;
                end
                romsu_pkg::C_OV_R: begin
                    rx = romsu_pkg::f_mk(romsu_pkg::f_inc(br), at, ar, ab);
                    rb = romsu_pkg::f_mk(bl, at, br, romsu_pkg::f_dec(bt));
                    ra.right = romsu_pkg::f_dec(bl);
                    n = 2'd3;
                end
                romsu_pkg::C_OV_RB: begin n = 2'd1; end
                romsu_pkg::C_OV_T: begin ra.right = romsu_pkg::f_dec(bl); n = 2'd1; end
                romsu_pkg::C_OV_TB: begin
                    rb = romsu_pkg::f_mk(bl, romsu_pkg::f_inc(bb), ar, ab);
                    ra.right = romsu_pkg::f_dec(bl);
                    n = 2'd2;
                end
                romsu_pkg::C_OV_TR: begin
                    rb = romsu_pkg::f_mk(romsu_pkg::f_inc(br), at, ar, ab);
                    ra.right = romsu_pkg::f_dec(bl);
                    n = 2'd2;
                end
                romsu_pkg::C_OV_TRB: begin
                    rx = romsu_pkg::f_mk(romsu_pkg::f_inc(br), at, ar, ab);
                    rb = romsu_pkg::f_mk(bl, romsu_pkg::f_inc(bb), br, ab);
                    ra.right = romsu_pkg::f_dec(bl);
                    n = 2'd3;
                end
                romsu_pkg::C_OV_L: begin ra.bottom = romsu_pkg::f_dec(bt); n = 2'd1; end
                romsu_pkg::C_OV_LB: begin
                    rb = romsu_pkg::f_mk(al, romsu_pkg::f_inc(bb), ar, ab);
                    ra.bottom = romsu_pkg::f_dec(bt);
                    n = 2'd2;
                end
                romsu_pkg::C_OV_LR: begin
                    rb = romsu_pkg::f_mk(romsu_pkg::f_inc(br), bt, ar, ab);
                    ra.bottom = romsu_pkg::f_dec(bt);
                    n = 2'd2;
                end
                romsu_pkg::C_OV_LRB: begin
                    rx = romsu_pkg::f_mk(al, romsu_pkg::f_inc(bb), ar, ab);
                    rb = romsu_pkg::f_mk(romsu_pkg::f_inc(br), bt, ar, bb);
                    ra.bottom = romsu_pkg::f_dec(bt);
                    n = 2'd3;
                end
                romsu_pkg::C_OV_LT: begin n = 2'd0; end
                romsu_pkg::C_OV_LTB: begin ra.top = romsu_pkg::f_inc(bb); n = 2'd1; end
                romsu_pkg::C_OV_LTR: begin ra.left = romsu_pkg::f_inc(br); n = 2'd1; end
                default: begin
                    rb = romsu_pkg::f_mk(romsu_pkg::f_inc(br), at, ar, bb);
                    ra.top = romsu_pkg::f_inc(bb);
                    n = 2'd2;
                end
            endcase
        end
    end

    // nothing left: a single all-zero result
    assign ea = (n == 2'd0) ? '0 : ra;

    assign done = r_active && (r_idx == r_last);
    assign take = i_valid && (!r_active || done);
    assign o_pop = take;

    always_comb begin
        case (r_idx)
            2'd0:    sel = r_rect[0];
            2'd1:    sel = r_rect[1];
            default: sel = r_rect[2];
        endcase
        n_out.rect_left   = sel.left;
        n_out.rect_top    = sel.top;
        n_out.rect_right  = sel.right;
        n_out.rect_bottom = sel.bottom;
        n_out.slot        = r_idx;
        n_out.rect_count  = r_count;
        n_out.empty_res   = (r_count == 2'd0);
        n_out.last        = (r_idx == r_last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_idx    <= 2'd0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_active;
            if (take) begin
                r_active <= 1'b1;
                r_idx    <= 2'd0;
            end else if (done) begin
                r_active <= 1'b0;
            end else if (r_active) begin
                r_idx <= 2'(r_idx + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_active) begin
            r_out <= n_out;
        end
        if (take) begin
            r_rect[0] <= ea;
            r_rect[1] <= rb;
            r_rect[2] <= rx;
            r_count   <= n;
            r_last    <= (n == 2'd0) ? 2'd0 : 2'(n - 2'd1);
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule
